[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, ignored while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

[src/lpb_pkg.sv]
// Package: types, codes and reset constants of the long-press button control
`default_nettype none
package lpb_pkg;

    localparam int unsigned TS_W   = 32;
    localparam int unsigned THR_W  = 16;
    localparam int unsigned MODE_W = 3;
    localparam int unsigned ACT_W  = 3;

    localparam logic [THR_W-1:0] SHORT_PRESS_RST = 16'd2000;
    localparam logic [THR_W-1:0] LONG_PRESS_RST  = 16'd5000;

    // configuration register indexes
    localparam logic REG_SHORT_PRESS = 1'b0;
    localparam logic REG_LONG_PRESS  = 1'b1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_MODE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WEBPAIR = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ZBPAIR  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NOPAIR  = 3'd4;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_PORTAL    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BROKER_HA = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MESH      = 3'd3;

    typedef struct packed {
        logic [THR_W-1:0] short_ms;
        logic [THR_W-1:0] long_ms;
    } t_cfg;

    typedef struct packed {
        logic             prev_level;
        logic [TS_W-1:0]  press_start;
        logic [TS_W-1:0]  press_duration;
        logic             blink;
        logic             red;
        logic             green;
    } t_state;

    typedef struct packed {
        logic              button_level;
        logic [TS_W-1:0]   now_ms;
        logic [MODE_W-1:0] current_mode;
        logic              link_up;
    } t_poll;

    typedef struct packed {
        logic              red_led;
        logic              green_led;
        logic              green_flash;
        logic [ACT_W-1:0]  action;
        logic [MODE_W-1:0] new_mode;
        logic              drop_link;
    } t_result;

    localparam t_state STATE_RST = '{
        prev_level:     1'b1,
        press_start:    '0,
        press_duration: '0,
        blink:          1'b0,
        red:            1'b0,
        green:          1'b0
    };

endpackage
`default_nettype wire

[src/lpb_cfg.sv]
// Threshold registers written through the configuration port
`default_nettype none
module lpb_cfg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_index,
    input  wire logic [lpb_pkg::THR_W-1:0] i_cfg_data,
    output lpb_pkg::t_cfg                  o_cfg
);
    import lpb_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_ms <= SHORT_PRESS_RST;
            r_cfg.long_ms  <= LONG_PRESS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SHORT_PRESS: r_cfg.short_ms <= i_cfg_data;
                REG_LONG_PRESS:  r_cfg.long_ms  <= i_cfg_data;
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[src/lpb_step.sv]
// Per-poll logic: press timing, LED blink and release classification
`default_nettype none
module lpb_step (
    input  wire lpb_pkg::t_cfg   i_cfg,
    input  wire lpb_pkg::t_state i_state,
    input  wire lpb_pkg::t_poll  i_poll,
    output lpb_pkg::t_state      o_state,
    output lpb_pkg::t_result     o_result
);
    import lpb_pkg::*;

    logic [TS_W-1:0] held_dur;
    logic            held_long;
    logic            held_short;
    logic            rel_long;
    logic            rel_short;
    logic            low_mode;
    logic [TS_W-1:0] short_ext;
    logic [TS_W-1:0] long_ext;

    assign short_ext  = {{(TS_W-THR_W){1'b0}}, i_cfg.short_ms};
    assign long_ext   = {{(TS_W-THR_W){1'b0}}, i_cfg.long_ms};
    assign held_dur   = i_poll.now_ms - i_state.press_start;
    assign held_long  = held_dur > long_ext;
    assign held_short = held_dur > short_ext;
    // release uses the duration from the last held poll
    assign rel_long   = i_state.press_duration > long_ext;
    assign rel_short  = i_state.press_duration > short_ext;
    assign low_mode   = i_poll.current_mode <= MODE_BROKER_HA;

    always_comb begin
        o_state              = i_state;
        o_result.green_flash = 1'b0;
        o_result.action      = ACT_NONE;
        o_result.new_mode    = i_poll.current_mode;
        o_result.drop_link   = 1'b0;

        if (!i_poll.button_level) begin
            o_result.green_flash = i_state.prev_level;
            o_state.prev_level     = 1'b0;
            o_state.press_duration = held_dur;
            if (held_long) begin
                o_state.blink = ~i_state.blink;
                o_state.red   = ~i_state.blink;
                o_state.green = 1'b0;
            end else if (held_short) begin
                o_state.blink = ~i_state.blink;
                o_state.red   = 1'b0;
                o_state.green = ~i_state.blink;
            end else begin
                o_state.red   = 1'b0;
                o_state.green = 1'b0;
            end
        end else begin
            if (!i_state.prev_level) begin
                if (rel_long) begin
                    o_result.action = ACT_MODE;
                    if (low_mode) begin
                        o_result.new_mode = MODE_MESH;
                        o_state.red       = 1'b1;
                        o_state.green     = 1'b0;
                    end else begin
                        o_result.new_mode = MODE_PORTAL;
                        o_state.red       = 1'b0;
                        o_state.green     = 1'b1;
                    end
                end else begin
                    if (rel_short) begin
                        if (low_mode) begin
                            o_result.action    = ACT_WEBPAIR;
                            o_result.drop_link = i_poll.link_up;
                        end else if (i_poll.current_mode == MODE_MESH) begin
                            o_result.action = ACT_ZBPAIR;
                        end else begin
                            o_result.action = ACT_NOPAIR;
                        end
                    end
                    o_state.red   = 1'b0;
                    o_state.green = 1'b0;
                end
            end
            o_state.prev_level  = 1'b1;
            o_state.press_start = i_poll.now_ms;
        end

        o_result.red_led   = o_state.red;
        o_result.green_led = o_state.green;
    end

endmodule
`default_nettype wire

[src/long_press_button_mode_control.sv]
// Top level: long-press button mode control with registered result stage
//
//  channel   direction  handshake                   payload
//  poll      in         i_in_valid / o_in_ready     button_level, now_ms, current_mode, link_up
//  result    out        o_out_valid / i_out_ready   red_led, green_led, green_flash, action,
//                                                   new_mode, drop_link
//  config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One poll per cycle while results are taken; its result shows in the cycle after the poll is taken.
// The rate is set by the single result register, which frees in the cycle it is read.
// A held result stalls the poll side until the result is taken.
// Reset: thresholds 2000 / 5000 ms, button released, LED state bits and blink bit cleared.
`default_nettype none
`include "assert_macros.svh"
module long_press_button_mode_control (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_index,
    input  wire logic [lpb_pkg::THR_W-1:0]  i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_button_level,
    input  wire logic [lpb_pkg::TS_W-1:0]   i_now_ms,
    input  wire logic [lpb_pkg::MODE_W-1:0] i_current_mode,
    input  wire logic                       i_link_up,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_red_led,
    output logic                            o_green_led,
    output logic                            o_green_flash,
    output logic [lpb_pkg::ACT_W-1:0]       o_action,
    output logic [lpb_pkg::MODE_W-1:0]      o_new_mode,
    output logic                            o_drop_link
);
    import lpb_pkg::*;

    t_cfg    cfg;
    t_poll   poll;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_take;

    lpb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign poll.button_level = i_button_level;
    assign poll.now_ms       = i_now_ms;
    assign poll.current_mode = i_current_mode;
    assign poll.link_up      = i_link_up;

    lpb_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_poll   (poll),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_state <= n_state;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_red_led     = r_result.red_led;
    assign o_green_led   = r_result.green_led;
    assign o_green_flash = r_result.green_flash;
    assign o_action      = r_result.action;
    assign o_new_mode    = r_result.new_mode;
    assign o_drop_link   = r_result.drop_link;

    `ASSERT_CLK(a_stall_blocks_in, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |-> !o_in_ready)
    `ASSERT_CLK(a_take_gives_out, i_clk, i_rst_n, in_take |=> r_out_valid)
    `ASSERT_CLK(a_drop_only_webpair, i_clk, i_rst_n,
                (r_out_valid && r_result.drop_link) |-> (r_result.action == ACT_WEBPAIR))
    `ASSERT_NEVER(a_flash_no_action, i_clk, i_rst_n,
                  r_out_valid && r_result.green_flash && (r_result.action != ACT_NONE))

endmodule
`default_nettype wire
